// ----- rtl/rrs_pkg.sv -----
`default_nettype none
package rrs_pkg;
   localparam int TASK_SLOTS = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int SW = $clog2(TASK_SLOTS);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] OP_SCHED  = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_SLEEP  = 3'd3;
   localparam logic [2:0] OP_LOAD   = 3'd4;
   localparam logic [2:0] OP_CHARGE = 3'd5;

   localparam logic [1:0] ST_UNUSED = 2'd0;
   localparam logic [1:0] ST_READY  = 2'd1;
   localparam logic [1:0] ST_ACTIVE = 2'd2;
   localparam logic [1:0] ST_SLEEP  = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_NOPID = 2'd2;

   // queue command from sequencer to run queue
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] wdata;
   } q_cmd_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       full;
      logic       empty;
      logic [CW-1:0] count;
   } q_stat_type;
endpackage
`default_nettype wire

// ----- rtl/rrs_queue.sv -----
`default_nettype none
module rrs_queue import rrs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_cmd_type  cmd,
   output q_stat_type      stat
);
   logic [7:0]    mem [QUEUE_DEPTH];
   logic [QW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [QW-1:0] tail;

   assign tail = QW'(({1'b0, head_ff} + (QW+1)'(count_ff)) % QUEUE_DEPTH);
   assign stat.rdata = mem[head_ff];
   assign stat.full = count_ff == CW'(QUEUE_DEPTH);
   assign stat.empty = count_ff == '0;
   assign stat.count = count_ff;

   // push and pop are never issued together
   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      if (cmd.push && !stat.full) count_in = count_ff + 1'b1;
      if (cmd.pop && !stat.empty) begin
         head_in = QW'((head_ff + 1'b1) % QUEUE_DEPTH);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
      end
      if (cmd.push && !stat.full) mem[tail] <= cmd.wdata;
   end
endmodule
`default_nettype wire

// ----- rtl/round_robin_scheduler_sleep_wake.sv -----
`default_nettype none
// sequence: simple ops go to S_DONE; schedule runs S_DROP, S_WAKE over all
// slots, S_POP, S_FIND if none selected, S_DONE; remove loops S_REM/S_REM2
// one request at a time: one table slot is visited per cycle by the sequencer
// throughput: next request accepted the cycle after the response is taken
// reset: synchronous, clears table, queue and selection; time_slice to 10
module round_robin_scheduler_sleep_wake import rrs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[2:0], slot[6:3], pid[14:7], entry_state[16:15], time_value[48:17]
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // current_valid[0], current_slot[4:1], current_pid[12:5],
   // queue_count[17:13], error[19:18]
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DROP = 4'd1, S_WAKE = 4'd2,
      S_POP = 4'd3, S_FIND = 4'd4, S_REM = 4'd5, S_REM2 = 4'd6, S_DONE = 4'd7;

   logic [3:0] st_ff, st_in;
   logic [1:0]  tstate_ff [TASK_SLOTS];
   logic [7:0]  tpid_ff [TASK_SLOTS];
   logic [31:0] wake_ff [TASK_SLOTS];
   logic [15:0] ticks_ff [TASK_SLOTS];
   logic [15:0] slice_ff;
   logic        cv_ff;
   logic [SW-1:0] cs_ff;
   logic [2:0]  op_ff;
   logic [31:0] now_ff;
   logic [SW:0] idx_ff;
   logic [CW-1:0] rem_ff;
   logic [7:0]  want_ff;
   logic [1:0]  err_ff;
   logic        rv_ff;
   logic [23:0] rd_ff;
   q_cmd_type   qc;
   q_stat_type  qs;

   logic [2:0]  r_op;
   logic [3:0]  r_slot;
   logic [7:0]  r_pid;
   logic [1:0]  r_est;
   logic [31:0] r_tv;
   logic [SW-1:0] ix;
   logic        slot_ok;

   assign r_op = req_tdata[2:0];
   assign r_slot = req_tdata[6:3];
   assign r_pid = req_tdata[14:7];
   assign r_est = req_tdata[16:15];
   assign r_tv = req_tdata[48:17];
   assign ix = idx_ff[SW-1:0];
   assign slot_ok = 32'(r_slot) < TASK_SLOTS;

   rrs_queue u_queue (.clock(clock), .reset(reset), .cmd(qc), .stat(qs));

   assign req_tready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;

   always_comb begin
      qc = '0;
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            case (r_op)
               OP_SCHED: st_in = S_DROP;
               OP_REMOVE: st_in = slot_ok ? S_REM : S_DONE;
               OP_ADD: begin
                  st_in = S_DONE;
                  if (slot_ok) begin
                     qc.push = 1'b1;
                     qc.wdata = tpid_ff[SW'(r_slot)];
                  end
               end
               default: st_in = S_DONE;
            endcase
         end
         S_DROP: begin
            st_in = S_WAKE;
            if (cv_ff && tstate_ff[cs_ff] == ST_ACTIVE && ticks_ff[cs_ff] >= slice_ff
                && tpid_ff[cs_ff] != 8'd0) begin
               qc.push = 1'b1;
               qc.wdata = tpid_ff[cs_ff];
            end
         end
         S_WAKE: begin
            if (tstate_ff[ix] == ST_SLEEP && wake_ff[ix] <= now_ff) begin
               qc.push = 1'b1;
               qc.wdata = tpid_ff[ix];
            end
            if (ix == SW'(TASK_SLOTS - 1)) st_in = S_POP;
         end
         S_POP: begin
            qc.pop = !cv_ff;
            st_in = cv_ff ? S_DONE : S_FIND;
         end
         S_FIND: if (cv_ff || ix == SW'(TASK_SLOTS - 1) || tpid_ff[ix] == want_ff)
            st_in = S_DONE;
         S_REM: begin
            if (rem_ff == '0) st_in = S_DONE;
            else begin
               qc.pop = 1'b1;
               st_in = (qs.rdata == want_ff) ? S_DONE : S_REM2;
            end
         end
         S_REM2: begin
            // requeue the entry popped in the previous cycle
            qc.push = 1'b1;
            qc.wdata = now_ff[7:0];
            st_in = S_REM;
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         slice_ff <= 16'd10;
         cv_ff <= 1'b0;
         cs_ff <= '0;
         rv_ff <= 1'b0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            tstate_ff[i] <= ST_UNUSED;
            tpid_ff[i] <= '0;
            wake_ff[i] <= '0;
            ticks_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (csr_we) slice_ff <= csr_wdata;
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               op_ff <= r_op;
               now_ff <= r_tv;
               idx_ff <= '0;
               err_ff <= ERR_NONE;
               rem_ff <= qs.count;
               case (r_op)
                  OP_ADD: if (slot_ok) begin
                     if (qs.full) err_ff <= ERR_FULL;
                     else tstate_ff[SW'(r_slot)] <= ST_READY;
                  end
                  OP_REMOVE: want_ff <= tpid_ff[SW'(r_slot)];
                  OP_SLEEP: if (slot_ok) begin
                     wake_ff[SW'(r_slot)] <= r_tv;
                     tstate_ff[SW'(r_slot)] <= ST_SLEEP;
                  end
                  OP_LOAD: if (slot_ok) begin
                     tpid_ff[SW'(r_slot)] <= r_pid;
                     tstate_ff[SW'(r_slot)] <= r_est;
                     wake_ff[SW'(r_slot)] <= '0;
                     ticks_ff[SW'(r_slot)] <= '0;
                  end
                  OP_CHARGE: if (cv_ff && ticks_ff[cs_ff] != 16'hFFFF)
                     ticks_ff[cs_ff] <= ticks_ff[cs_ff] + 1'b1;
                  default: ;
               endcase
            end
            S_DROP: begin
               if (cv_ff && tstate_ff[cs_ff] != ST_ACTIVE) cv_ff <= 1'b0;
               else if (cv_ff && ticks_ff[cs_ff] >= slice_ff) begin
                  ticks_ff[cs_ff] <= '0;
                  cv_ff <= 1'b0;
                  if (tpid_ff[cs_ff] == 8'd0) tstate_ff[cs_ff] <= ST_READY;
                  else if (qs.full) err_ff <= ERR_FULL;
                  else tstate_ff[cs_ff] <= ST_READY;
               end
            end
            S_WAKE: begin
               if (tstate_ff[ix] == ST_SLEEP && wake_ff[ix] <= now_ff) begin
                  ticks_ff[ix] <= '0;
                  wake_ff[ix] <= '0;
                  if (qs.full) begin
                     if (err_ff == ERR_NONE) err_ff <= ERR_FULL;
                  end else tstate_ff[ix] <= ST_READY;
               end
               idx_ff <= (ix == SW'(TASK_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
            end
            S_POP: if (!cv_ff) want_ff <= qs.empty ? 8'd0 : qs.rdata;
            S_FIND: if (!cv_ff) begin
               if (tpid_ff[ix] == want_ff) begin
                  cv_ff <= 1'b1;
                  cs_ff <= ix;
               end else if (ix == SW'(TASK_SLOTS - 1)) begin
                  if (err_ff == ERR_NONE) err_ff <= ERR_NOPID;
               end
               idx_ff <= idx_ff + 1'b1;
            end
            S_REM: if (rem_ff != '0) begin
               rem_ff <= rem_ff - 1'b1;
               if (qs.rdata != want_ff) now_ff <= {24'd0, qs.rdata};
            end
            default: ;
         endcase
         if (st_ff == S_DONE) begin
            if (op_ff == OP_SCHED && cv_ff) tstate_ff[cs_ff] <= ST_ACTIVE;
            rv_ff <= 1'b1;
            rd_ff <= {4'd0, err_ff, 5'(qs.count),
                      cv_ff ? tpid_ff[cs_ff] : 8'd0,
                      cv_ff ? 4'(cs_ff) : 4'd0, cv_ff};
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/rrs_checker.sv -----
`default_nettype none
module rrs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:18] != 2'd3) else $error("bad error code");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:13] <= 5'd16) else $error("queue count");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[12:1] == 12'd0)
      else $error("stale selection");
endmodule
bind round_robin_scheduler_sleep_wake rrs_checker u_chk (.*);
`default_nettype wire
